>>> rtl/cbhn_pkg.sv
`default_nettype none

package cbhn_pkg;

  // Window geometry
  localparam int TAP_HALF = 6;
  localparam int NUM_TAPS = 2 * TAP_HALF + 1;
  localparam int HALF_A   = (TAP_HALF + 1) / 2;   // neighbor steps done in the first stage

  // Adder tree grouping
  localparam int GRP     = 4;
  localparam int NUM_GRP = (NUM_TAPS + GRP - 1) / GRP;

  // Datapath widths
  localparam int IDX_W    = 16;
  localparam int NOISE_W  = 16;
  localparam int SUM_W    = NOISE_W + $clog2(NUM_TAPS);
  localparam int T_W      = SUM_W - 1;
  localparam int SAMPLE_W = 15;

  // Floor reciprocal of the tap count; the quotient estimate is at most one low
  localparam int RECIP = (2 ** T_W) / NUM_TAPS;

  // Hash constants
  localparam logic [31:0] HASH_MUL1 = 32'h9E37_79B1;
  localparam logic [31:0] HASH_ADD1 = 32'h27D4_EB2F;
  localparam logic [31:0] HASH_MUL2 = 32'h2C1B_3C6D;

  localparam logic [IDX_W-1:0] LOOP_LENGTH_RST = IDX_W'(22050);

  // Register map (word index taken from paddr[2])
  localparam logic REG_LOOP_LENGTH = 1'b0;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [NOISE_W-1:0] noise_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [T_W-1:0]            quo_t;

  // Circular successor / predecessor inside [0, len)
  function automatic idx_t idx_inc(input idx_t idx, input idx_t len);
    logic [IDX_W:0] s;
    s = {1'b0, idx} + (IDX_W+1)'(1);
    return (s == {1'b0, len}) ? '0 : s[IDX_W-1:0];
  endfunction

  function automatic idx_t idx_dec(input idx_t idx, input idx_t len);
    return (idx == '0) ? (len - idx_t'(1)) : (idx - idx_t'(1));
  endfunction

endpackage

`default_nettype wire

>>> rtl/circular_boxcar_hash_noise.sv
`default_nettype none

// Filtered noise sample generator for a looping buffer. Each start transfer
// carries one sample index; the matching result is then on out_sample /
// out_index_error for exactly one cycle, flagged by out_valid. The result
// passes through the register stages: neighbor indices (2), hash (3),
// adder tree (2), scale and reciprocal divide (2), then the output
// register. A new index may be issued every cycle (busy is always low) and
// results leave in issue order; the receiver cannot stall, so nothing waits
// in the block. The sample is a 13-tap moving average of hashed white noise
// around the index, with neighbors wrapping modulo loop_length, scaled by
// 32767/(26*32768) and truncated toward zero. An index at or above loop_length
// returns sample 0 with index_error set. loop_length (APB offset 0x0, reset
// 22050) must only be written while no result is pending.
module circular_boxcar_hash_noise (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // command channel
  input  wire                                  start,
  output logic                                 busy,
  input  wire  [cbhn_pkg::IDX_W-1:0]           in_sample_index,
  // result channel
  output logic                                 out_valid,
  output logic signed [cbhn_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                 out_index_error,
  // configuration (APB-style)
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [2:0]                           paddr,
  input  wire  [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import cbhn_pkg::*;

  localparam int NSTG = 9;   // stages ahead of the output register

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  idx_t loop_len_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOOP_LENGTH) ? {16'b0, loop_len_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_len_r <= LOOP_LENGTH_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LOOP_LENGTH)) begin
      loop_len_r <= pwdata[IDX_W-1:0];
    end
  end

  // Fully pipelined, never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Valid / error flags travel alongside the data
  // ---------------------------------------------------------------------------
  logic [NSTG:1] vld_r;
  logic [NSTG:1] err_r;
  logic          in_xfer;
  logic          in_err;

  assign in_xfer = start && !busy;
  assign in_err  = (in_sample_index >= loop_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-1:1], in_xfer};
    end
  end

  always_ff @(posedge clk) begin
    err_r <= {err_r[NSTG-1:1], in_err};
  end

  // ---------------------------------------------------------------------------
  // Stages 1-2: neighbor indices, one circular step per tap outward
  // ---------------------------------------------------------------------------
  idx_t lane1_nxt [NUM_TAPS];
  idx_t lane1_r   [NUM_TAPS];
  idx_t lane2_nxt [NUM_TAPS];
  idx_t lane2_r   [NUM_TAPS];

  always_comb begin
    for (int j = 0; j < NUM_TAPS; j++) begin
      lane1_nxt[j] = '0;
    end
    lane1_nxt[TAP_HALF] = in_sample_index;
    for (int s = 1; s <= HALF_A; s++) begin
      lane1_nxt[TAP_HALF+s] = idx_inc(lane1_nxt[TAP_HALF+s-1], loop_len_r);
      lane1_nxt[TAP_HALF-s] = idx_dec(lane1_nxt[TAP_HALF-s+1], loop_len_r);
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_TAPS; j++) begin
      lane2_nxt[j] = lane1_r[j];
    end
    for (int s = HALF_A + 1; s <= TAP_HALF; s++) begin
      lane2_nxt[TAP_HALF+s] = idx_inc(lane2_nxt[TAP_HALF+s-1], loop_len_r);
      lane2_nxt[TAP_HALF-s] = idx_dec(lane2_nxt[TAP_HALF-s+1], loop_len_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3-5: per-lane hash, one multiply each in stages 3 and 4, none in the final stage
  // ---------------------------------------------------------------------------
  logic [31:0] h1_nxt    [NUM_TAPS];
  logic [31:0] h1_r      [NUM_TAPS];
  logic [31:0] h2_nxt    [NUM_TAPS];
  logic [31:0] h2_r      [NUM_TAPS];
  noise_t      noise_nxt [NUM_TAPS];
  noise_t      noise_r   [NUM_TAPS];

  always_comb begin
    logic [31:0] g;
    logic [31:0] f;
    for (int j = 0; j < NUM_TAPS; j++) begin
      h1_nxt[j]    = {{(32-IDX_W){1'b0}}, lane2_r[j]} * HASH_MUL1 + HASH_ADD1;
      g            = h1_r[j] ^ (h1_r[j] >> 15);
      h2_nxt[j]    = g * HASH_MUL2;
      f            = h2_r[j] ^ (h2_r[j] >> 12);
      // low half minus 32768 == low half with its top bit flipped, as signed
      noise_nxt[j] = noise_t'(f[NOISE_W-1:0] ^ {1'b1, {(NOISE_W-1){1'b0}}});
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 6-7: registered adder tree
  // ---------------------------------------------------------------------------
  sum_t grp_nxt [NUM_GRP];
  sum_t grp_r   [NUM_GRP];
  sum_t sum_nxt;
  sum_t sum_r;

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_nxt[g] = '0;
      for (int m = 0; m < GRP; m++) begin
        if (g * GRP + m < NUM_TAPS) begin
          grp_nxt[g] = grp_nxt[g] + sum_t'(noise_r[g*GRP+m]);
        end
      end
    end
    sum_nxt = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      sum_nxt = sum_nxt + grp_r[g];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 8-9: |sum| * 32767 / 65536, then divide by the tap count via
  // reciprocal multiply; the output register stage corrects by one and restores sign.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0]    mag;
  logic [SUM_W+14:0]   scaled;
  quo_t                t8_nxt;
  quo_t                t8_r;
  logic                neg8_r;
  logic [2*T_W-1:0]    qprod;
  quo_t                q9_nxt;
  quo_t                q9_r;
  quo_t                t9_r;
  logic                neg9_r;

  always_comb begin
    mag    = sum_r[SUM_W-1] ? (SUM_W)'(-sum_r) : (SUM_W)'(sum_r);
    scaled = {mag, 15'b0} - {15'b0, mag};
    t8_nxt = scaled[SUM_W+14:16];
    qprod  = {{T_W{1'b0}}, t8_r} * (2*T_W)'(RECIP);
    q9_nxt = qprod[2*T_W-1:T_W];
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [T_W:0]                    rem;
  quo_t                            q_fix;
  logic signed [SAMPLE_W-1:0]      sample_nxt;
  logic                            out_valid_r;
  logic signed [SAMPLE_W-1:0]      out_sample_r;
  logic                            out_index_error_r;

  always_comb begin
    rem   = {1'b0, t9_r} - (T_W+1)'(q9_r * quo_t'(NUM_TAPS));
    q_fix = (rem >= (T_W+1)'(NUM_TAPS)) ? (q9_r + quo_t'(1)) : q9_r;
    if (err_r[NSTG]) begin
      sample_nxt = '0;
    end else if (neg9_r) begin
      sample_nxt = SAMPLE_W'(-q_fix);
    end else begin
      sample_nxt = SAMPLE_W'(q_fix);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    lane1_r <= lane1_nxt;
    lane2_r <= lane2_nxt;
    h1_r    <= h1_nxt;
    h2_r    <= h2_nxt;
    noise_r <= noise_nxt;
    grp_r   <= grp_nxt;
    sum_r   <= sum_nxt;
    t8_r    <= t8_nxt;
    neg8_r  <= sum_r[SUM_W-1];
    q9_r    <= q9_nxt;
    t9_r    <= t8_r;
    neg9_r  <= neg8_r;
    out_sample_r      <= sample_nxt;
    out_index_error_r <= err_r[NSTG];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NSTG];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_index_error = out_index_error_r;

endmodule

`default_nettype wire
